// ----- rtl/assert_macros.svh -----
// assertion helpers used by the pool manager rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/rbpm_pkg.sv -----
package rbpm_pkg;

   // pool geometry
   localparam int SLOT_COUNT = 32;
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int REFS_W = 8;
   localparam int WIDE_W = 16;

   // port field widths
   localparam int FIELD_OP_W = 3;
   localparam int FIELD_IDX_W = 5;
   localparam int FIELD_CNT_W = 6;

   localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

   // opcodes
   localparam logic [FIELD_OP_W-1:0] OP_ALLOC       = 3'd0;
   localparam logic [FIELD_OP_W-1:0] OP_ALLOC_SPARE = 3'd1;
   localparam logic [FIELD_OP_W-1:0] OP_RELEASE     = 3'd2;
   localparam logic [FIELD_OP_W-1:0] OP_ADD_REFS    = 3'd3;
   localparam logic [FIELD_OP_W-1:0] OP_SET_LINK    = 3'd4;

   // one slot record: link and reference count
   typedef struct packed {
      logic              link_ok;
      logic [IDX_W-1:0]  link_idx;
      logic [REFS_W-1:0] refs;
   } entry_type;

   // free list head
   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] idx;
   } head_type;

   // latched transaction operands
   typedef struct packed {
      logic [FIELD_OP_W-1:0] op;
      logic [IDX_W-1:0]      slot;
      logic                  slot_ok;
      logic [REFS_W-1:0]     inc;
      logic [IDX_W-1:0]      tgt;
      logic                  tgt_ok;
   } cmd_type;

   // execute stage outcome
   typedef struct packed {
      logic             wr_en;
      entry_type        wr_entry;
      head_type         head;
      logic [CNT_W-1:0] used;
      logic [CNT_W-1:0] peak;
      logic             ok;
      logic [IDX_W-1:0] res_idx;
      logic             res_ok;
      logic             returned;
   } exec_type;

   // contents of a slot right after reset
   function automatic entry_type reset_entry(input logic [IDX_W-1:0] idx);
      entry_type e;
      e.link_ok = (idx != '0);
      e.link_idx = (idx != '0) ? idx - IDX_W'(1) : '0;
      e.refs = '0;
      return e;
   endfunction

endpackage

// ----- rtl/refcounted_buffer_pool_manager.sv -----
// channel    ports                         transfer
// request    start, busy, req_*            start high while busy low
// response   rsp_valid, rsp_*              one cycle strobe, always taken
//
// every transaction has a read step and an execute step: the accept edge
// reads the slot record from the slot memory, the next cycle modifies it,
// writes it back and registers the response. busy is high in that execute
// cycle, so a new transaction is taken in the cycle the response is shown.
// synchronous reset needs no clearing pass: per-slot written flags return
// the reset contents. the response side cannot stall.
`include "assert_macros.svh"

module refcounted_buffer_pool_manager (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [rbpm_pkg::FIELD_OP_W-1:0]         req_opcode,
   input  logic [rbpm_pkg::FIELD_IDX_W-1:0]        req_buffer_index,
   input  logic [rbpm_pkg::REFS_W-1:0]             req_reference_increment,
   input  logic [rbpm_pkg::FIELD_IDX_W-1:0]        req_link_index,
   input  logic                                    req_link_valid,
   output logic                                    rsp_valid,
   output logic                                    rsp_ok,
   output logic [rbpm_pkg::FIELD_IDX_W-1:0]        rsp_result_index,
   output logic                                    rsp_result_index_valid,
   output logic                                    rsp_returned_to_pool,
   output logic [rbpm_pkg::FIELD_CNT_W-1:0]        rsp_used_slots,
   output logic [rbpm_pkg::FIELD_CNT_W-1:0]        rsp_peak_used_slots
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   rbpm_pkg::cmd_type cmd_ff, cmd_in;
   logic [rbpm_pkg::IDX_W-1:0] addr_ff, addr_in;
   rbpm_pkg::head_type head_ff;
   logic [rbpm_pkg::CNT_W-1:0] used_ff;
   logic [rbpm_pkg::CNT_W-1:0] peak_ff;
   logic rsp_valid_ff;
   logic rsp_ok_ff;
   logic [rbpm_pkg::FIELD_IDX_W-1:0] rsp_idx_ff;
   logic rsp_idx_ok_ff;
   logic rsp_returned_ff;
   logic [rbpm_pkg::FIELD_CNT_W-1:0] rsp_used_ff;
   logic [rbpm_pkg::FIELD_CNT_W-1:0] rsp_peak_ff;

   logic accept;
   logic exec;
   logic req_is_alloc;
   rbpm_pkg::entry_type rd_entry;
   rbpm_pkg::exec_type res;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec = (state_ff == ST_EXEC);
   assign busy = exec;
   assign req_is_alloc = (req_opcode == rbpm_pkg::OP_ALLOC) ||
                         (req_opcode == rbpm_pkg::OP_ALLOC_SPARE);

   // operand capture and memory address for the incoming transaction
   always_comb begin
      cmd_in.op = req_opcode;
      cmd_in.slot = rbpm_pkg::IDX_W'(req_buffer_index);
      cmd_in.slot_ok = rbpm_pkg::WIDE_W'(req_buffer_index) <
                       rbpm_pkg::WIDE_W'(rbpm_pkg::SLOT_COUNT);
      cmd_in.inc = req_reference_increment;
      cmd_in.tgt = rbpm_pkg::IDX_W'(req_link_index);
      cmd_in.tgt_ok = req_link_valid &&
                      (rbpm_pkg::WIDE_W'(req_link_index) <
                       rbpm_pkg::WIDE_W'(rbpm_pkg::SLOT_COUNT));
      addr_in = req_is_alloc ? head_ff.idx : cmd_in.slot;
      state_in = accept ? ST_EXEC : ST_IDLE;
   end

   rbpm_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (addr_in),
      .rd_data (rd_entry),
      .wr_en   (exec && res.wr_en),
      .wr_addr (addr_ff),
      .wr_data (res.wr_entry)
   );

   rbpm_exec u_exec (
      .cmd   (cmd_ff),
      .entry (rd_entry),
      .head  (head_ff),
      .used  (used_ff),
      .peak  (peak_ff),
      .res   (res)
   );

   // operand registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
         addr_ff <= addr_in;
      end
   end

   // control state and pool counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff.ok <= 1'b1;
         head_ff.idx <= rbpm_pkg::IDX_W'(rbpm_pkg::SLOT_COUNT - 1);
         used_ff <= '0;
         peak_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= exec;
         if (exec) begin
            head_ff <= res.head;
            used_ff <= res.used;
            peak_ff <= res.peak;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_ok_ff <= res.ok;
         rsp_idx_ff <= rbpm_pkg::FIELD_IDX_W'(res.res_idx);
         rsp_idx_ok_ff <= res.res_ok;
         rsp_returned_ff <= res.returned;
         rsp_used_ff <= rbpm_pkg::FIELD_CNT_W'(res.used);
         rsp_peak_ff <= rbpm_pkg::FIELD_CNT_W'(res.peak);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ok_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_result_index_valid = rsp_idx_ok_ff;
   assign rsp_returned_to_pool = rsp_returned_ff;
   assign rsp_used_slots = rsp_used_ff;
   assign rsp_peak_used_slots = rsp_peak_ff;

   `ASSERT_NEXT(a_accept_exec, clock, reset, accept, busy && !rsp_valid)
   `ASSERT_NEXT(a_exec_resp, clock, reset, exec, rsp_valid && !busy)
   `ASSERT_SAME(a_peak_bound, clock, reset, 1'b1, used_ff <= peak_ff)
   `ASSERT_SAME(a_used_bound, clock, reset, 1'b1,
      used_ff <= rbpm_pkg::CNT_W'(rbpm_pkg::SLOT_COUNT))
   `ASSERT_SAME(a_fail_empty, clock, reset, rsp_valid && !rsp_ok,
      !rsp_result_index_valid && !rsp_returned_to_pool)

endmodule

// ----- rtl/rbpm_slot_mem.sv -----
module rbpm_slot_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [rbpm_pkg::IDX_W-1:0]    rd_addr,
   output rbpm_pkg::entry_type           rd_data,
   input  logic                          wr_en,
   input  logic [rbpm_pkg::IDX_W-1:0]    wr_addr,
   input  rbpm_pkg::entry_type           wr_data
);

   rbpm_pkg::entry_type slot_mem_ff [rbpm_pkg::SLOT_COUNT];
   logic [rbpm_pkg::SLOT_COUNT-1:0] written_ff;
   rbpm_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
   end

   // per-entry written flags, unwritten entries read as reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? slot_mem_ff[rd_addr]
                                           : rbpm_pkg::reset_entry(rd_addr);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rbpm_exec.sv -----
module rbpm_exec (
   input  rbpm_pkg::cmd_type               cmd,
   input  rbpm_pkg::entry_type             entry,
   input  rbpm_pkg::head_type              head,
   input  logic [rbpm_pkg::CNT_W-1:0]      used,
   input  logic [rbpm_pkg::CNT_W-1:0]      peak,
   output rbpm_pkg::exec_type              res
);

   logic is_alloc;
   logic alloc_fail;
   logic [rbpm_pkg::REFS_W:0] refs_sum;
   logic [rbpm_pkg::CNT_W-1:0] used_up;

   assign is_alloc = (cmd.op == rbpm_pkg::OP_ALLOC) || (cmd.op == rbpm_pkg::OP_ALLOC_SPARE);
   assign alloc_fail = !head.ok ||
                       ((cmd.op == rbpm_pkg::OP_ALLOC_SPARE) && !entry.link_ok);
   assign refs_sum = {1'b0, entry.refs} + {1'b0, cmd.inc};
   assign used_up = (used < rbpm_pkg::CNT_W'(rbpm_pkg::SLOT_COUNT)) ?
                    used + rbpm_pkg::CNT_W'(1) : used;

   // decode and apply one transaction to the slot record and pool counters
   always_comb begin
      res.wr_en = 1'b0;
      res.wr_entry = entry;
      res.head = head;
      res.used = used;
      res.peak = peak;
      res.ok = 1'b1;
      res.res_idx = '0;
      res.res_ok = 1'b0;
      res.returned = 1'b0;

      if (is_alloc) begin
         if (alloc_fail) begin
            res.ok = 1'b0;
         end else begin
            // pop head slot
            res.head.ok = entry.link_ok;
            res.head.idx = entry.link_idx;
            res.wr_en = 1'b1;
            res.wr_entry.link_ok = 1'b0;
            res.wr_entry.link_idx = '0;
            res.wr_entry.refs = rbpm_pkg::REFS_W'(1);
            res.used = used_up;
            res.peak = (used_up > peak) ? used_up : peak;
            res.res_idx = head.idx;
            res.res_ok = 1'b1;
         end
      end else if (cmd.slot_ok) begin
         res.res_idx = entry.link_ok ? entry.link_idx : '0;
         res.res_ok = entry.link_ok;
         case (cmd.op)
            rbpm_pkg::OP_RELEASE: begin
               res.wr_en = 1'b1;
               if (entry.refs > rbpm_pkg::REFS_W'(1)) begin
                  res.wr_entry.refs = entry.refs - rbpm_pkg::REFS_W'(1);
               end else begin
                  // push slot back on the free list
                  res.wr_entry.link_ok = head.ok;
                  res.wr_entry.link_idx = head.idx;
                  res.head.ok = 1'b1;
                  res.head.idx = cmd.slot;
                  res.used = (used != '0) ? used - rbpm_pkg::CNT_W'(1) : used;
                  res.returned = 1'b1;
               end
            end
            rbpm_pkg::OP_ADD_REFS: begin
               res.wr_en = 1'b1;
               res.wr_entry.refs = refs_sum[rbpm_pkg::REFS_W] ? rbpm_pkg::REFS_MAX
                                                              : refs_sum[rbpm_pkg::REFS_W-1:0];
            end
            rbpm_pkg::OP_SET_LINK: begin
               res.wr_en = 1'b1;
               res.wr_entry.link_ok = cmd.tgt_ok;
               res.wr_entry.link_idx = cmd.tgt_ok ? cmd.tgt : '0;
            end
            default: begin
               // unused opcode: no change, empty result
               res.res_idx = '0;
               res.res_ok = 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import rbpm_pkg::*;

   // opcodes above set link are unused and must change nothing
   localparam logic [FIELD_OP_W-1:0] OP_UNUSED_FIRST = OP_SET_LINK + 1'b1;
   localparam logic [FIELD_OP_W-1:0] OP_UNUSED_LAST  = '1;
   localparam int PRINT_CAP = 100;

   // one response as the block should show it
   typedef struct packed {
      logic                   ok;
      logic [FIELD_IDX_W-1:0] idx;
      logic                   idx_ok;
      logic                   returned;
      logic [FIELD_CNT_W-1:0] used;
      logic [FIELD_CNT_W-1:0] peak;
   } pool_rsp_t;

   // pool bookkeeping mirror plus the responses still owed by the block
   class pool_scoreboard;
      logic [IDX_W-1:0]  link_idx [SLOT_COUNT];
      bit                link_ok [SLOT_COUNT];
      logic [REFS_W-1:0] refs [SLOT_COUNT];
      logic [IDX_W-1:0]  head_idx;
      bit                head_ok;
      int unsigned       used_cnt;
      int unsigned       peak_cnt;
      pool_rsp_t         pending_rsps [$];
      int                errors;

      // state right after reset: full free list from the top slot down
      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            link_idx[i] = (i == 0) ? '0 : IDX_W'(i - 1);
            link_ok[i] = (i != 0);
            refs[i] = '0;
         end
         head_idx = IDX_W'(SLOT_COUNT - 1);
         head_ok = 1'b1;
         used_cnt = 0;
         peak_cnt = 0;
         errors = 0;
      endfunction

      task report_mismatch(input string what, input int got_val, input int want_val);
         errors++;
         if (errors <= PRINT_CAP) begin
            $display("%0t mismatch %s: got %0d, wanted %0d", $realtime, what, got_val,
                     want_val);
         end
      endtask

      // a live slot when there is one, any slot otherwise
      function logic [IDX_W-1:0] pick_live_slot();
         logic [IDX_W-1:0] live [$];
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (refs[i] != 0) begin
               live.push_back(IDX_W'(i));
            end
         end
         if (live.size() == 0) begin
            return IDX_W'($urandom_range(0, SLOT_COUNT - 1));
         end
         return live[$urandom_range(0, live.size() - 1)];
      endfunction

      // apply one accepted transaction and queue the response it owes
      function void note_request(input logic [FIELD_OP_W-1:0] op,
                                 input logic [FIELD_IDX_W-1:0] slot,
                                 input logic [REFS_W-1:0] inc,
                                 input logic [FIELD_IDX_W-1:0] tgt,
                                 input logic tgt_ok);
         pool_rsp_t r;
         logic [IDX_W-1:0] h;
         int sum;
         r = '0;
         r.ok = 1'b1;
         case (op)
            OP_ALLOC, OP_ALLOC_SPARE: begin
               h = head_idx;
               // empty pool, or the spare-keeping form on the last free slot
               if (!head_ok || (op == OP_ALLOC_SPARE && !link_ok[h])) begin
                  r.ok = 1'b0;
               end else begin
                  head_idx = link_idx[h];
                  head_ok = link_ok[h];
                  link_idx[h] = '0;
                  link_ok[h] = 1'b0;
                  refs[h] = REFS_W'(1);
                  if (used_cnt < SLOT_COUNT) begin
                     used_cnt++;
                  end
                  if (used_cnt > peak_cnt) begin
                     peak_cnt = used_cnt;
                  end
                  r.idx = h;
                  r.idx_ok = 1'b1;
               end
            end
            OP_RELEASE, OP_ADD_REFS, OP_SET_LINK: begin
               // every 5-bit slot lies inside a 32-slot pool
               r.idx = link_ok[slot] ? link_idx[slot] : '0;
               r.idx_ok = link_ok[slot];
               if (op == OP_RELEASE) begin
                  if (refs[slot] > 1) begin
                     refs[slot]--;
                  end else begin
                     link_idx[slot] = head_idx;
                     link_ok[slot] = head_ok;
                     head_idx = slot;
                     head_ok = 1'b1;
                     if (used_cnt > 0) begin
                        used_cnt--;
                     end
                     r.returned = 1'b1;
                  end
               end else if (op == OP_ADD_REFS) begin
                  sum = int'(refs[slot]) + int'(inc);
                  refs[slot] = (sum > int'(REFS_MAX)) ? REFS_MAX : REFS_W'(sum);
               end else begin
                  link_idx[slot] = tgt_ok ? tgt : '0;
                  link_ok[slot] = tgt_ok;
               end
            end
            default: begin
            end
         endcase
         r.used = FIELD_CNT_W'(used_cnt);
         r.peak = FIELD_CNT_W'(peak_cnt);
         pending_rsps.push_back(r);
      endfunction

      // compare one response with the oldest one owed
      task check_response(input pool_rsp_t got);
         pool_rsp_t want;
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with no transaction pending", 1, 0);
            return;
         end
         want = pending_rsps.pop_front();
         if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
         if (got.idx !== want.idx) report_mismatch("result_index", got.idx, want.idx);
         if (got.idx_ok !== want.idx_ok) begin
            report_mismatch("result_index_valid", got.idx_ok, want.idx_ok);
         end
         if (got.returned !== want.returned) begin
            report_mismatch("returned_to_pool", got.returned, want.returned);
         end
         if (got.used !== want.used) report_mismatch("used_slots", got.used, want.used);
         if (got.peak !== want.peak) begin
            report_mismatch("peak_used_slots", got.peak, want.peak);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [FIELD_OP_W-1:0]  req_opcode = '0;
   logic [FIELD_IDX_W-1:0] req_buffer_index = '0;
   logic [REFS_W-1:0]      req_reference_increment = '0;
   logic [FIELD_IDX_W-1:0] req_link_index = '0;
   logic                   req_link_valid = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ok;
   logic [FIELD_IDX_W-1:0] rsp_result_index;
   logic                   rsp_result_index_valid;
   logic                   rsp_returned_to_pool;
   logic [FIELD_CNT_W-1:0] rsp_used_slots;
   logic [FIELD_CNT_W-1:0] rsp_peak_used_slots;

   pool_scoreboard pool_sb;

   refcounted_buffer_pool_manager DUT (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_opcode              (req_opcode),
      .req_buffer_index        (req_buffer_index),
      .req_reference_increment (req_reference_increment),
      .req_link_index          (req_link_index),
      .req_link_valid          (req_link_valid),
      .rsp_valid               (rsp_valid),
      .rsp_ok                  (rsp_ok),
      .rsp_result_index        (rsp_result_index),
      .rsp_result_index_valid  (rsp_result_index_valid),
      .rsp_returned_to_pool    (rsp_returned_to_pool),
      .rsp_used_slots          (rsp_used_slots),
      .rsp_peak_used_slots     (rsp_peak_used_slots)
   );

   // clock
   always #4 clock = ~clock;

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         pool_sb.check_response(pool_rsp_t'{rsp_ok, rsp_result_index, rsp_result_index_valid,
                                            rsp_returned_to_pool, rsp_used_slots,
                                            rsp_peak_used_slots});
      end
   end

   // present one transaction and hold it until the block takes it
   task automatic send_request(input logic [FIELD_OP_W-1:0] op,
                               input logic [FIELD_IDX_W-1:0] slot,
                               input logic [REFS_W-1:0] inc,
                               input logic [FIELD_IDX_W-1:0] tgt,
                               input logic tgt_ok);
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_buffer_index <= slot;
      req_reference_increment <= inc;
      req_link_index <= tgt;
      req_link_valid <= tgt_ok;
      do @(posedge clock); while (busy);
      pool_sb.note_request(op, slot, inc, tgt, tgt_ok);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // mostly well-formed bookkeeping on live slots, some noise
   task automatic send_random_item(input int alloc_pct);
      logic [FIELD_OP_W-1:0]  op;
      logic [FIELD_IDX_W-1:0] slot;
      logic [REFS_W-1:0]      inc;
      logic [FIELD_IDX_W-1:0] tgt;
      logic                   tgt_ok;
      int                     roll;
      slot = pool_sb.pick_live_slot();
      tgt = FIELD_IDX_W'($urandom);
      tgt_ok = ($urandom_range(0, 3) != 0);
      inc = ($urandom_range(0, 7) == 0) ? REFS_W'($urandom) : REFS_W'($urandom_range(0, 2));
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
         op = ($urandom_range(0, 3) == 0) ? OP_ALLOC_SPARE : OP_ALLOC;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            op = OP_RELEASE;
         end else if (roll < 70) begin
            op = OP_ADD_REFS;
         end else if (roll < 85) begin
            op = OP_SET_LINK;
         end else if (roll < 90) begin
            // self loop on the free-list head hands one slot out twice
            op = OP_SET_LINK;
            slot = pool_sb.head_idx;
            tgt = slot;
            tgt_ok = 1'b1;
         end else if (roll < 96) begin
            // any slot, live or free
            op = OP_RELEASE + FIELD_OP_W'($urandom_range(0, 2));
            slot = FIELD_IDX_W'($urandom);
         end else begin
            op = FIELD_OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         end
      end
      send_request(op, slot, inc, tgt, tgt_ok);
   endtask

   // stimulus
   initial begin
      logic [IDX_W-1:0] h;
      logic [IDX_W-1:0] saved_link;
      logic             saved_ok;
      pool_sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: both allocates, count extremes, link writes, stray releases
      send_request(OP_ALLOC_SPARE, '0, '0, '0, 1'b0);
      send_request(OP_ALLOC, '1, '1, '1, 1'b1);
      send_request(OP_ADD_REFS, 5'd31, REFS_MAX, '0, 1'b0);
      send_request(OP_ADD_REFS, 5'd30, '0, '1, 1'b1);
      send_request(OP_RELEASE, 5'd31, '0, '0, 1'b0);
      send_request(OP_SET_LINK, 5'd30, '0, 5'd5, 1'b1);
      send_request(OP_SET_LINK, 5'd30, '0, '1, 1'b0);
      send_request(OP_SET_LINK, 5'd30, '0, '1, 1'b1);
      send_request(OP_RELEASE, 5'd30, '0, '0, 1'b0);
      send_request(OP_RELEASE, 5'd0, '0, '0, 1'b0);
      send_request(OP_RELEASE, 5'd31, '0, '0, 1'b0);
      send_request(OP_RELEASE, 5'd5, '0, '0, 1'b0);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
         send_request(FIELD_OP_W'(op), '1, '1, '1, 1'b1);
      end

      // directed: last spare and empty pool, then put the free list back
      h = pool_sb.head_idx;
      saved_link = pool_sb.link_idx[h];
      saved_ok = pool_sb.link_ok[h];
      send_request(OP_SET_LINK, h, '0, '0, 1'b0);
      send_request(OP_ALLOC_SPARE, '0, '0, '0, 1'b0);
      send_request(OP_ALLOC, '0, '0, '0, 1'b0);
      send_request(OP_ALLOC, '0, '0, '0, 1'b0);
      send_request(OP_ALLOC_SPARE, '0, '0, '0, 1'b0);
      send_request(OP_RELEASE, h, '0, '0, 1'b0);
      send_request(OP_SET_LINK, h, '0, saved_link, saved_ok);

      // random phases swing between draining and refilling the pool
      for (int phase = 0; phase < 8; phase++) begin
         for (int n = 0; n < 104; n++) begin
            if (phase < 6 && phase != 2 && $urandom_range(0, 3) == 0) begin
               idle_cycles($urandom_range(1, 16));
            end
            send_random_item((phase % 2 == 0) ? 65 : 25);
         end
      end

      // drain
      idle_cycles(1);
      while (pool_sb.pending_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (pool_sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
